[rtl/ycbcr420_to_bgr_flip_top_assert.svh]
`ifndef YCBCR420_TO_BGR_FLIP_TOP_ASSERT_SVH
`define YCBCR420_TO_BGR_FLIP_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define YBF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define YBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

[rtl/ybf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ybf_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int TABLE_BITS    = 7;

   localparam int SIZE_W = 13;
   localparam int BLK_W  = 11;
   localparam int BCNT_W = 12;
   localparam int IDX_W  = 24;
   localparam int PIX_W  = 8;
   localparam int OFF_W  = 9;
   localparam int PROD_W = 27;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam logic [PIX_W-1:0] QUANT_MASK = PIX_W'(8'hFF << (8 - TABLE_BITS));

   localparam logic signed [17:0] COEF_R  = 18'sd91881;
   localparam logic signed [17:0] COEF_GB = 18'sd22554;
   localparam logic signed [17:0] COEF_GR = 18'sd46802;
   localparam logic signed [17:0] COEF_B  = 18'sd116130;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_QUANTIZE     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [3:0][PIX_W-1:0]    luma;
      logic signed [OFF_W-1:0]  r_off;
      logic signed [OFF_W-1:0]  g_off;
      logic signed [OFF_W-1:0]  b_off;
      logic [IDX_W-1:0]         idx_top;
      logic [IDX_W-1:0]         idx_bot;
      logic                     last_block;
   } entry_type;

   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] count;
   } qstat_type;

   function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] reg_value);
      logic [SIZE_W-1:0] v;
      v = {reg_value[SIZE_W-1:1], 1'b0};
      if (v < SIZE_W'(2)) begin
         v = SIZE_W'(2);
      end else if (v > SIZE_W'(MAX_DIMENSION)) begin
         v = SIZE_W'(MAX_DIMENSION) & ~SIZE_W'(1);
      end
      return v;
   endfunction

   function automatic logic [PIX_W-1:0] clamp8(input logic signed [OFF_W:0] v);
      logic [PIX_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > (OFF_W+1)'(255)) begin
         r = '1;
      end else begin
         r = v[PIX_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/ybf_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ybf_front (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_write,
   input  wire [1:0]                   csr_index,
   input  wire [ybf_pkg::SIZE_W-1:0]   csr_data,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire [ybf_pkg::PIX_W-1:0]    req_luma_top_left,
   input  wire [ybf_pkg::PIX_W-1:0]    req_luma_top_right,
   input  wire [ybf_pkg::PIX_W-1:0]    req_luma_bottom_left,
   input  wire [ybf_pkg::PIX_W-1:0]    req_luma_bottom_right,
   input  wire [ybf_pkg::PIX_W-1:0]    req_chroma_blue,
   input  wire [ybf_pkg::PIX_W-1:0]    req_chroma_red,
   output logic                        push_o,
   output ybf_pkg::entry_type          entry_o,
   input  ybf_pkg::qstat_type          qstat_i
);
   import ybf_pkg::*;

   logic [SIZE_W-1:0] frame_width_ff, frame_width_in;
   logic [SIZE_W-1:0] frame_height_ff, frame_height_in;
   logic              quantize_ff, quantize_in;

   logic [SIZE_W-1:0] w_eff, h_eff;
   logic [BCNT_W-1:0] bcols, brows;
   logic [BLK_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [BLK_W-1:0]  col_use, row_use;
   logic [BCNT_W-1:0] col_inc, row_inc;
   logic              col_wrap, row_wrap;
   logic              accept;
   logic [PIX_W-1:0]  qmask;
   logic [3:0]        inflight;

   // stage 1: quantised samples and block position
   logic                        s1_valid_ff, s1_valid_in;
   logic [3:0][PIX_W-1:0]       s1_luma_ff, s1_luma_in;
   logic signed [OFF_W-1:0]     s1_dcb_ff, s1_dcb_in, s1_dcr_ff, s1_dcr_in;
   logic [BLK_W-1:0]            s1_col_ff, s1_row_ff;
   logic                        s1_last_ff, s1_last_in;

   // stage 2: products
   logic                        s2_valid_ff, s2_valid_in;
   logic [3:0][PIX_W-1:0]       s2_luma_ff;
   logic signed [PROD_W-1:0]    s2_prod_r_ff, s2_prod_r_in;
   logic signed [PROD_W-1:0]    s2_prod_gb_ff, s2_prod_gb_in;
   logic signed [PROD_W-1:0]    s2_prod_gr_ff, s2_prod_gr_in;
   logic signed [PROD_W-1:0]    s2_prod_b_ff, s2_prod_b_in;
   logic [IDX_W-1:0]            s2_rowprod_ff;
   logic [BCNT_W-1:0]           s2_x0_ff;
   logic                        s2_last_ff;

   logic [SIZE_W-1:0]           dest_top;
   logic [2*SIZE_W-1:0]         rowprod_full;
   logic signed [PROD_W:0]      g_sum;
   logic [IDX_W-1:0]            idx_top;

   assign w_eff = effective_size(frame_width_ff);
   assign h_eff = effective_size(frame_height_ff);
   assign bcols = w_eff[SIZE_W-1:1];
   assign brows = h_eff[SIZE_W-1:1];

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      quantize_in     = quantize_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            CSR_QUANTIZE:     quantize_in     = csr_data[0];
            default: ;
         endcase
      end
   end

   // hold back new blocks unless every one in flight has a queue slot
   assign inflight  = 4'(qstat_i.count) + 4'(s1_valid_ff) + 4'(s2_valid_ff);
   assign req_stall = inflight >= 4'(QDEPTH);
   assign accept    = req_valid && !req_stall;

   // drop a counter that a size change has left out of range
   assign col_use  = ({1'b0, col_ff} >= bcols) ? '0 : col_ff;
   assign row_use  = ({1'b0, row_ff} >= brows) ? '0 : row_ff;
   assign col_inc  = {1'b0, col_use} + BCNT_W'(1);
   assign row_inc  = {1'b0, row_use} + BCNT_W'(1);
   assign col_wrap = col_inc >= bcols;
   assign row_wrap = row_inc >= brows;

   assign qmask = quantize_ff ? QUANT_MASK : '1;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = accept;
      s1_luma_in  = {req_luma_bottom_right & qmask, req_luma_bottom_left & qmask,
                     req_luma_top_right & qmask, req_luma_top_left & qmask};
      s1_dcb_in   = $signed({1'b0, req_chroma_blue & qmask}) - OFF_W'(128);
      s1_dcr_in   = $signed({1'b0, req_chroma_red & qmask}) - OFF_W'(128);
      s1_last_in  = col_wrap && row_wrap;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_inc[BLK_W-1:0];
         end else begin
            col_in = col_inc[BLK_W-1:0];
            row_in = row_use;
         end
      end
   end

   assign s2_valid_in   = s1_valid_ff;
   assign s2_prod_r_in  = COEF_R * s1_dcr_ff;
   assign s2_prod_gb_in = COEF_GB * s1_dcb_ff;
   assign s2_prod_gr_in = COEF_GR * s1_dcr_ff;
   assign s2_prod_b_in  = COEF_B * s1_dcb_ff;
   assign dest_top      = h_eff - SIZE_W'(1) - {1'b0, s1_row_ff, 1'b0};
   assign rowprod_full  = dest_top * w_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= SIZE_W'(2);
         frame_height_ff <= SIZE_W'(2);
         quantize_ff     <= 1'b1;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         quantize_ff     <= quantize_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_luma_ff <= s1_luma_in;
         s1_dcb_ff  <= s1_dcb_in;
         s1_dcr_ff  <= s1_dcr_in;
         s1_col_ff  <= col_use;
         s1_row_ff  <= row_use;
         s1_last_ff <= s1_last_in;
      end
      if (s1_valid_ff) begin
         s2_luma_ff    <= s1_luma_ff;
         s2_prod_r_ff  <= s2_prod_r_in;
         s2_prod_gb_ff <= s2_prod_gb_in;
         s2_prod_gr_ff <= s2_prod_gr_in;
         s2_prod_b_ff  <= s2_prod_b_in;
         s2_rowprod_ff <= rowprod_full[IDX_W-1:0];
         s2_x0_ff      <= {s1_col_ff, 1'b0};
         s2_last_ff    <= s1_last_ff;
      end
   end

   // floor of the Q16 terms: keep bits 24..16 after an arithmetic shift
   assign g_sum   = -((PROD_W+1)'(s2_prod_gb_ff) + (PROD_W+1)'(s2_prod_gr_ff));
   assign idx_top = s2_rowprod_ff + IDX_W'(s2_x0_ff);

   always_comb begin
      entry_o.luma       = s2_luma_ff;
      entry_o.r_off      = s2_prod_r_ff[16+OFF_W-1:16];
      entry_o.g_off      = g_sum[16+OFF_W-1:16];
      entry_o.b_off      = s2_prod_b_ff[16+OFF_W-1:16];
      entry_o.idx_top    = idx_top;
      entry_o.idx_bot    = idx_top - IDX_W'(w_eff);
      entry_o.last_block = s2_last_ff;
   end

   assign push_o = s2_valid_ff;

endmodule

`default_nettype wire

[rtl/ybf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ycbcr420_to_bgr_flip_top_assert.svh"

module ybf_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_i,
   input  ybf_pkg::entry_type  entry_i,
   input  wire                 pop_i,
   output ybf_pkg::entry_type  head_o,
   output ybf_pkg::qstat_type  qstat_o
);
   import ybf_pkg::*;

   entry_type          mem [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_i ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_i ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push_i) - QCNT_W'(pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem[wr_ptr_ff] <= entry_i;
      end
   end

   assign head_o        = mem[rd_ptr_ff];
   assign qstat_o.empty = count_ff == '0;
   assign qstat_o.count = count_ff;

   `YBF_ASSERT_IMPL(a_no_overflow, clock, reset, push_i, count_ff < QCNT_W'(QDEPTH))
   `YBF_ASSERT_IMPL(a_no_underflow, clock, reset, pop_i, count_ff != '0)
   `YBF_ASSERT_NEXT(a_count_tracks, clock, reset, push_i && !pop_i, count_ff == $past(count_ff) + QCNT_W'(1))

endmodule

`default_nettype wire

[rtl/ybf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ycbcr420_to_bgr_flip_top_assert.svh"

module ybf_back (
   input  wire                        clock,
   input  wire                        reset,
   input  ybf_pkg::entry_type         head_i,
   input  ybf_pkg::qstat_type         qstat_i,
   output logic                       pop_o,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [ybf_pkg::IDX_W-1:0]  rsp_pixel_index,
   output logic [ybf_pkg::PIX_W-1:0]  rsp_red,
   output logic [ybf_pkg::PIX_W-1:0]  rsp_green,
   output logic [ybf_pkg::PIX_W-1:0]  rsp_blue,
   output logic                       rsp_last_of_block,
   output logic                       rsp_last_of_frame
);
   import ybf_pkg::*;

   logic [1:0]              k_ff, k_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        rsp_pixel_index_ff, rsp_pixel_index_in;
   logic [PIX_W-1:0]        rsp_red_ff, rsp_red_in;
   logic [PIX_W-1:0]        rsp_green_ff, rsp_green_in;
   logic [PIX_W-1:0]        rsp_blue_ff, rsp_blue_in;
   logic                    rsp_last_of_block_ff, rsp_last_of_block_in;
   logic                    rsp_last_of_frame_ff, rsp_last_of_frame_in;
   logic                    load;
   logic signed [OFF_W:0]   luma_ext;

   // load a pixel whenever the output register is empty or being taken
   assign load  = !qstat_i.empty && (!rsp_valid_ff || !rsp_stall);
   assign pop_o = load && (k_ff == 2'd3);

   always_comb begin
      luma_ext             = $signed({2'b00, head_i.luma[k_ff]});
      k_in                 = load ? k_ff + 2'd1 : k_ff;
      rsp_valid_in         = load || (rsp_valid_ff && rsp_stall);
      rsp_pixel_index_in   = (k_ff[1] ? head_i.idx_bot : head_i.idx_top) + IDX_W'(k_ff[0]);
      rsp_red_in           = clamp8(luma_ext + (OFF_W+1)'(head_i.r_off));
      rsp_green_in         = clamp8(luma_ext + (OFF_W+1)'(head_i.g_off));
      rsp_blue_in          = clamp8(luma_ext + (OFF_W+1)'(head_i.b_off));
      rsp_last_of_block_in = k_ff == 2'd3;
      rsp_last_of_frame_in = (k_ff == 2'd3) && head_i.last_block;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_pixel_index_ff   <= rsp_pixel_index_in;
         rsp_red_ff           <= rsp_red_in;
         rsp_green_ff         <= rsp_green_in;
         rsp_blue_ff          <= rsp_blue_in;
         rsp_last_of_block_ff <= rsp_last_of_block_in;
         rsp_last_of_frame_ff <= rsp_last_of_frame_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_index   = rsp_pixel_index_ff;
   assign rsp_red           = rsp_red_ff;
   assign rsp_green         = rsp_green_ff;
   assign rsp_blue          = rsp_blue_ff;
   assign rsp_last_of_block = rsp_last_of_block_ff;
   assign rsp_last_of_frame = rsp_last_of_frame_ff;

   `YBF_ASSERT_IMPL(a_frame_end_in_block, clock, reset, rsp_valid_ff && rsp_last_of_frame_ff, rsp_last_of_block_ff)
   `YBF_ASSERT_NEXT(a_load_shows, clock, reset, load, rsp_valid_ff && (rsp_last_of_block_ff == $past(k_ff == 2'd3)))
   `YBF_ASSERT_IMPL(a_block_keeps_head, clock, reset, k_ff != 2'd0, !qstat_i.empty)

endmodule

`default_nettype wire

[rtl/ycbcr420_to_bgr_flip_top.sv]
// Full-range 4:2:0 colour converter. Each transaction on req_ carries one 2x2 luma block
// with its shared Cb and Cr, in raster block order; rsp_ returns four pixels per block
// (top-left, top-right, bottom-left, bottom-right) with clamped red, green and blue and
// the pixel index in a bottom-up frame. A block is taken each cycle until four blocks are
// held between the two front stages and the four-entry queue, the block being unpacked
// included. The result port delivers one pixel a cycle while rsp_stall is low, which sets
// the sustained rate. A block passes the stage 1 and stage 2 registers and the queue
// before its first pixel reaches the output register. The user must write frame size and
// quantise mode through csr_ only while no block is in flight; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module ycbcr420_to_bgr_flip_top (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_write,
   input  wire [1:0]                   csr_index,
   input  wire [ybf_pkg::SIZE_W-1:0]   csr_data,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire [ybf_pkg::PIX_W-1:0]    req_luma_top_left,
   input  wire [ybf_pkg::PIX_W-1:0]    req_luma_top_right,
   input  wire [ybf_pkg::PIX_W-1:0]    req_luma_bottom_left,
   input  wire [ybf_pkg::PIX_W-1:0]    req_luma_bottom_right,
   input  wire [ybf_pkg::PIX_W-1:0]    req_chroma_blue,
   input  wire [ybf_pkg::PIX_W-1:0]    req_chroma_red,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [ybf_pkg::IDX_W-1:0]   rsp_pixel_index,
   output logic [ybf_pkg::PIX_W-1:0]   rsp_red,
   output logic [ybf_pkg::PIX_W-1:0]   rsp_green,
   output logic [ybf_pkg::PIX_W-1:0]   rsp_blue,
   output logic                        rsp_last_of_block,
   output logic                        rsp_last_of_frame
);
   import ybf_pkg::*;

   logic       push;
   logic       pop;
   entry_type  push_entry;
   entry_type  head;
   qstat_type  qstat;

   ybf_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_luma_top_left     (req_luma_top_left),
      .req_luma_top_right    (req_luma_top_right),
      .req_luma_bottom_left  (req_luma_bottom_left),
      .req_luma_bottom_right (req_luma_bottom_right),
      .req_chroma_blue       (req_chroma_blue),
      .req_chroma_red        (req_chroma_red),
      .push_o                (push),
      .entry_o               (push_entry),
      .qstat_i               (qstat)
   );

   ybf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .entry_i (push_entry),
      .pop_i   (pop),
      .head_o  (head),
      .qstat_o (qstat)
   );

   ybf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_i            (head),
      .qstat_i           (qstat),
      .pop_o             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_index   (rsp_pixel_index),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_last_of_block (rsp_last_of_block),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

`default_nettype wire
